[rtl/rgb_to_hsl_converter_unit_assert.svh]
// Assertion macros for the RGB to HSL converter.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef RGB_TO_HSL_CONVERTER_UNIT_ASSERT_SVH
`define RGB_TO_HSL_CONVERTER_UNIT_ASSERT_SVH

// check while out of reset
`define RHC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rhc assertion failed");

// check at every edge, reset included
`define RHC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("rhc assertion failed during reset");

`endif

[rtl/rhc_pkg.sv]
// Package for the RGB to HSL converter: widths, beat types and pipeline types.
// No dependencies.
`default_nettype none

package rhc_pkg;

  localparam int ChannelBits = 8;
  localparam int FracBits    = 16;
  localparam int SumW        = ChannelBits + 1;
  localparam int DivW        = ChannelBits + 3;
  localparam int NumW        = ChannelBits + 4;

  localparam logic [ChannelBits-1:0] ChanFull = {ChannelBits{1'b1}};
  localparam logic [SumW-1:0]        SumFull  = {1'b0, ChanFull};
  localparam logic [SumW-1:0]        SumMax   = {ChanFull, 1'b0};

  typedef enum logic [1:0] {
    SecRed,
    SecGreen,
    SecBlue
  } sector_e;

  typedef struct packed {
    logic [ChannelBits-1:0] red;
    logic [ChannelBits-1:0] green;
    logic [ChannelBits-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [FracBits-1:0] hue;
    logic [FracBits-1:0] saturation;
    logic [SumW-1:0]     lightness_sum;
  } hsl_t;

  typedef struct packed {
    logic [ChannelBits-1:0] mn;
    logic [ChannelBits-1:0] mx;
    logic signed [SumW-1:0] diff;
    sector_e                sector;
  } front_t;

  typedef struct packed {
    logic [DivW-1:0]     rem;
    logic [DivW-1:0]     dvs;
    logic [FracBits-1:0] quo;
  } lane_t;

  typedef struct packed {
    lane_t           hue;
    lane_t           sat;
    logic [SumW-1:0] lsum;
    logic            grey;
  } pipe_t;

endpackage

`default_nettype wire

[rtl/rhc_front.sv]
// Front end of the converter: min/max and sector pick, then divider set-up.
// Two register stages; depends on rhc_pkg.
`default_nettype none

module rhc_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire rhc_pkg::pixel_t data_i,
  output logic                 valid_o,
  output rhc_pkg::pipe_t       data_o
);

  localparam int C = rhc_pkg::ChannelBits;
  localparam int F = rhc_pkg::FracBits;

  rhc_pkg::front_t fr_d, fr_q;
  logic            va_q, vb_q;
  rhc_pkg::pipe_t  pb_d, pb_q;

  logic [C-1:0]                 delta;
  logic [rhc_pkg::SumW-1:0]     sum;
  logic [rhc_pkg::SumW-1:0]     den_w;
  logic [rhc_pkg::DivW-1:0]     six;
  logic signed [rhc_pkg::NumW-1:0] base, num;
  logic [C+F-1:0]               sat_div;

  always_comb begin
    fr_d.mn = data_i.red;
    if (data_i.green < fr_d.mn) fr_d.mn = data_i.green;
    if (data_i.blue  < fr_d.mn) fr_d.mn = data_i.blue;
    fr_d.mx = data_i.red;
    if (data_i.green > fr_d.mx) fr_d.mx = data_i.green;
    if (data_i.blue  > fr_d.mx) fr_d.mx = data_i.blue;
    if (data_i.red >= data_i.green && data_i.red >= data_i.blue) begin
      fr_d.sector = rhc_pkg::SecRed;
      fr_d.diff   = $signed({1'b0, data_i.green}) - $signed({1'b0, data_i.blue});
    end else if (data_i.green >= data_i.blue) begin
      fr_d.sector = rhc_pkg::SecGreen;
      fr_d.diff   = $signed({1'b0, data_i.blue}) - $signed({1'b0, data_i.red});
    end else begin
      fr_d.sector = rhc_pkg::SecBlue;
      fr_d.diff   = $signed({1'b0, data_i.red}) - $signed({1'b0, data_i.green});
    end
  end

  always_comb begin
    delta = fr_q.mx - fr_q.mn;
    sum   = {1'b0, fr_q.mx} + {1'b0, fr_q.mn};
    den_w = (sum < rhc_pkg::SumFull) ? sum : rhc_pkg::SumMax - sum;
    six   = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
    case (fr_q.sector)
      rhc_pkg::SecRed:   base = '0;
      rhc_pkg::SecGreen: base = $signed({3'b000, delta, 1'b0});
      rhc_pkg::SecBlue:  base = $signed({2'b00, delta, 2'b00});
      default:           base = '0;
    endcase
    num = base + rhc_pkg::NumW'(fr_q.diff);
    if (num < 0) num = num + $signed({1'b0, six});
    sat_div = {delta, {F{1'b0}}} - {{F{1'b0}}, delta};

    pb_d.hue.rem = num[rhc_pkg::DivW-1:0];
    pb_d.hue.dvs = six;
    pb_d.hue.quo = '0;
    pb_d.sat.rem = {3'b000, sat_div[C+F-1:F]};
    pb_d.sat.dvs = {2'b00, den_w};
    pb_d.sat.quo = sat_div[F-1:0];
    pb_d.lsum    = sum;
    pb_d.grey    = (delta == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fr_q <= fr_d;
      pb_q <= pb_d;
    end
  end

  assign valid_o = vb_q;
  assign data_o  = pb_q;

endmodule

`default_nettype wire

[rtl/rhc_div_stage.sv]
// One restoring-division step for the hue and saturation lanes.
// One register stage; depends on rhc_pkg.
`default_nettype none

module rhc_div_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire rhc_pkg::pipe_t data_i,
  output logic                valid_o,
  output rhc_pkg::pipe_t      data_o
);

  localparam int W = rhc_pkg::DivW;
  localparam int F = rhc_pkg::FracBits;

  function automatic rhc_pkg::lane_t div_step(input rhc_pkg::lane_t l);
    rhc_pkg::lane_t r;
    logic [W:0]     t;
    logic [W:0]     s;
    logic           ge;
    t  = {l.rem, l.quo[F-1]};
    s  = t - {1'b0, l.dvs};
    ge = (t >= {1'b0, l.dvs});
    r.rem = ge ? s[W-1:0] : t[W-1:0];
    r.dvs = l.dvs;
    r.quo = {l.quo[F-2:0], ge};
    return r;
  endfunction

  rhc_pkg::pipe_t p_d, p_q;
  logic           v_q;

  always_comb begin
    p_d      = data_i;
    p_d.hue  = div_step(data_i.hue);
    p_d.sat  = div_step(data_i.sat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = p_q;

endmodule

`default_nettype wire

[rtl/rgb_to_hsl_converter_unit.sv]
// Top level of the RGB to HSL converter: front end plus division pipeline.
// Depends on rhc_pkg, rhc_front, rhc_div_stage and the assertion header.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries one pixel beat (red, green,
//   blue). Output channel out_valid_o/out_ready_i carries one HSL beat (hue,
//   saturation, lightness_sum) for every pixel, in order.
//   Pipeline: 18 register stages (two front stages, then one restoring-division
//   step per hue/saturation bit, 16 stages) lie between input and output.
//   Throughput: one beat per cycle while the output is not stalled; each
//   division bit has its own stage.
//   Grey pixels give hue 0 and saturation 0.
//   Stall: the whole pipeline, bubbles included, holds while a result waits at
//   the output and out_ready_i is low; in_ready_o is then low. Beats keep
//   entering while the output is free or being taken.
//   Reset: rst_ni clears all valid bits at once; no beat is in flight after.
`default_nettype none

`include "rgb_to_hsl_converter_unit_assert.svh"

module rgb_to_hsl_converter_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire rhc_pkg::pixel_t in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output rhc_pkg::hsl_t        out_data_o
);

  localparam int F = rhc_pkg::FracBits;

  rhc_pkg::pipe_t stg [F+1];
  logic [F:0]     vld;
  logic           en;

  assign en         = !vld[F] || out_ready_i;
  assign in_ready_o = en;

  rhc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (vld[0]),
    .data_o  (stg[0])
  );

  for (genvar i = 0; i < F; i++) begin : g_div
    rhc_div_stage u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[i]),
      .data_i  (stg[i]),
      .valid_o (vld[i+1]),
      .data_o  (stg[i+1])
    );
  end

  assign out_valid_o              = vld[F];
  assign out_data_o.hue           = stg[F].grey ? '0 : stg[F].hue.quo;
  assign out_data_o.saturation    = stg[F].grey ? '0 : stg[F].sat.quo;
  assign out_data_o.lightness_sum = stg[F].lsum;

  `RHC_ASSERT(a_lsum_range, out_valid_o |-> out_data_o.lightness_sum <= rhc_pkg::SumMax)
  `RHC_ASSERT(a_sat_not_extreme, (out_valid_o && out_data_o.saturation != '0) |-> (out_data_o.lightness_sum != '0 && out_data_o.lightness_sum != rhc_pkg::SumMax))
  `RHC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o)

endmodule

`default_nettype wire
